// ===== rtl/cpu_task_scheduler_defines.svh =====
// ---------------------------------------------------------------------------
// cpu_task_scheduler_defines
// assertion macros shared by the scheduler rtl
// ---------------------------------------------------------------------------
`ifndef CPU_TASK_SCHEDULER_DEFINES_SVH
`define CPU_TASK_SCHEDULER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define CTS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define CTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/cts_pkg.sv =====
// ---------------------------------------------------------------------------
// cts_pkg
// types, constants and helpers of the cpu task scheduler
// ---------------------------------------------------------------------------
`default_nettype none

package cts_pkg;

  localparam int MAX_TASKS = 16;
  localparam int TIDX_W    = $clog2(MAX_TASKS);
  localparam int TCNT_W    = $clog2(MAX_TASKS + 1);
  localparam int TIME_W    = 32;
  localparam int ID_W      = 8;
  localparam int PRIO_W    = 8;
  localparam int TICK_W    = 16;
  localparam int MODE_W    = 3;

  localparam logic [MODE_W-1:0] MODE_FCFS = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SJF  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PRIO = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RR   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_PRR  = 3'd4;

  localparam logic CFG_MODE    = 1'b0;
  localparam logic CFG_QUANTUM = 1'b1;

  localparam logic [TICK_W-1:0] QUANTUM_RST = 16'd2;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_CLEAR   = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_SLICE   = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_RUN_RD,
    S_RUN_CHK,
    S_QCHK,
    S_QSCAN,
    S_SHIFT,
    S_TASK_RD,
    S_TASK_UPD
  } state_t;

  typedef enum logic [1:0] {
    K_ADMIT,
    K_EARLY,
    K_PICK
  } scan_kind_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic [TICK_W-1:0] arr;
    logic [TICK_W-1:0] burst;
  } tbl_entry_t;

  typedef struct packed {
    logic [TIDX_W-1:0] idx;
    logic [PRIO_W-1:0] prio;
  } q_entry_t;

  // ring position head + off, off at most MAX_TASKS
  function automatic logic [TIDX_W-1:0] qwrap(input logic [TIDX_W-1:0] head,
                                               input logic [TCNT_W-1:0] off);
    logic [TCNT_W:0] sum;
    sum = (TCNT_W+1)'(head) + (TCNT_W+1)'(off);
    if (sum >= (TCNT_W+1)'(MAX_TASKS)) begin
      sum = sum - (TCNT_W+1)'(MAX_TASKS);
    end
    return sum[TIDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/cts_ram.sv =====
// ---------------------------------------------------------------------------
// cts_ram
// simple dual-port synchronous ram with registered read
// ---------------------------------------------------------------------------
`default_nettype none

module cts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cpu_task_scheduler.sv =====
// ---------------------------------------------------------------------------
// cpu_task_scheduler
// task table with fcfs, shortest job, priority and round robin slice picking
// ---------------------------------------------------------------------------
// usage:
//   commands enter on start while busy is low: load task, clear table,
//   restart schedule and next slice. load, clear and restart finish in the
//   accepting cycle and give no result.
//   a next-slice command raises busy; one result is shown on out_valid for
//   a single cycle as busy falls. the receiver cannot stall.
//   a slice is found by scans, paced by the single read port of the task
//   table and of the queue: fcfs, shortest job and priority modes take
//   one or two table scans (three when nothing has arrived); round robin
//   modes take an admit scan, an optional earliest-arrival scan and second
//   admit scan, a queue scan and a queue shift of up to the picked position.
//   configuration writes on cfg_we take effect at once; write only while
//   idle. modes 5 to 7 make a slice command a no-op.
//   reset empties the table, the queue and the time and sets fcfs with a
//   quantum of two.
// ---------------------------------------------------------------------------
`default_nettype none
`include "cpu_task_scheduler_defines.svh"

module cpu_task_scheduler (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    in_cmd,
  input  wire logic [cts_pkg::ID_W-1:0]      in_task_id,
  input  wire logic [cts_pkg::PRIO_W-1:0]    in_task_priority,
  input  wire logic [cts_pkg::TICK_W-1:0]    in_arrival_time,
  input  wire logic [cts_pkg::TICK_W-1:0]    in_burst_time,
  output logic                               out_valid,
  output logic [cts_pkg::ID_W-1:0]           out_slice_task_id,
  output logic [cts_pkg::TICK_W-1:0]         out_slice_length,
  output logic                               out_status,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [cts_pkg::TICK_W-1:0]    cfg_wdata
);

  localparam int MT = cts_pkg::MAX_TASKS;
  localparam int IW = cts_pkg::TIDX_W;
  localparam int CW = cts_pkg::TCNT_W;

  cts_pkg::state_t     state_r, state_nxt;
  cts_pkg::scan_kind_t kind_r, kind_nxt;

  logic [cts_pkg::MODE_W-1:0] mode_r;
  logic [cts_pkg::TICK_W-1:0] quantum_r;
  logic [CW-1:0]              count_r, count_nxt;
  logic [cts_pkg::TIME_W-1:0] time_r, time_nxt;
  logic [MT-1:0]              adm_r, adm_nxt;
  logic [MT-1:0]              dirty_r, dirty_nxt;
  logic [IW-1:0]              q_head_r, q_head_nxt;
  logic [CW-1:0]              q_cnt_r, q_cnt_nxt;
  logic                       run_valid_r, run_valid_nxt;
  logic [IW-1:0]              run_idx_r, run_idx_nxt;
  logic                       phase_r, phase_nxt;

  logic [CW-1:0]              scan_i_r, scan_i_nxt;
  logic                       rd_vld_r, rd_vld_nxt;
  logic [IW-1:0]              rd_idx_r, rd_idx_nxt;
  logic                       qrd_vld_r, qrd_vld_nxt;
  logic [CW-1:0]              qrd_k_r, qrd_k_nxt;
  logic [CW-1:0]              shift_k_r, shift_k_nxt;
  logic                       sh_wr_vld_r, sh_wr_vld_nxt;
  logic [IW-1:0]              sh_waddr_r, sh_waddr_nxt;

  logic                       best_found_r, best_found_nxt;
  logic [IW-1:0]              best_idx_r, best_idx_nxt;
  logic [cts_pkg::TICK_W-1:0] best_arr_r, best_arr_nxt;
  logic [cts_pkg::TICK_W-1:0] best_rem_r, best_rem_nxt;
  logic [cts_pkg::PRIO_W-1:0] best_prio_r, best_prio_nxt;
  logic [CW-1:0]              best_k_r, best_k_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [cts_pkg::ID_W-1:0]   out_id_r, out_id_nxt;
  logic [cts_pkg::TICK_W-1:0] out_len_r, out_len_nxt;
  logic                       out_status_r, out_status_nxt;

  logic                       tbl_we, tbl_re;
  logic [IW-1:0]              tbl_waddr, tbl_raddr;
  cts_pkg::tbl_entry_t        tbl_wdata, tbl_rdata;
  logic                       rem_we;
  logic [IW-1:0]              rem_waddr;
  logic [cts_pkg::TICK_W-1:0] rem_wdata, rem_rdata;
  logic                       q_we, q_re;
  logic [IW-1:0]              q_waddr, q_raddr;
  cts_pkg::q_entry_t          q_wdata, q_rdata;

  logic [cts_pkg::TICK_W-1:0] rem_eff;
  logic [cts_pkg::TICK_W-1:0] q_eff;
  logic [cts_pkg::TICK_W-1:0] len;
  logic [cts_pkg::TIME_W-1:0] t_base;
  logic                       pend, arrived, better;

  cts_ram #(.WIDTH($bits(cts_pkg::tbl_entry_t)), .DEPTH(MT)) u_tbl (
    .clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
    .re(tbl_re), .raddr(tbl_raddr), .rdata(tbl_rdata)
  );

  cts_ram #(.WIDTH(cts_pkg::TICK_W), .DEPTH(MT)) u_rem (
    .clk(clk), .we(rem_we), .waddr(rem_waddr), .wdata(rem_wdata),
    .re(tbl_re), .raddr(tbl_raddr), .rdata(rem_rdata)
  );

  cts_ram #(.WIDTH($bits(cts_pkg::q_entry_t)), .DEPTH(MT)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .re(q_re), .raddr(q_raddr), .rdata(q_rdata)
  );

  // untouched entries still hold their loaded burst
  assign rem_eff = dirty_r[rd_idx_r] ? rem_rdata : tbl_rdata.burst;
  assign q_eff   = (quantum_r == '0) ? cts_pkg::TICK_W'(1) : quantum_r;
  assign pend    = !adm_r[rd_idx_r];
  assign arrived = cts_pkg::TIME_W'(tbl_rdata.arr) <= time_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= cts_pkg::MODE_FCFS;
      quantum_r <= cts_pkg::QUANTUM_RST;
    end else if (cfg_we) begin
      if (cfg_index == cts_pkg::CFG_MODE) begin
        mode_r <= cfg_wdata[cts_pkg::MODE_W-1:0];
      end else begin
        quantum_r <= cfg_wdata;
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    count_nxt      = count_r;
    time_nxt       = time_r;
    adm_nxt        = adm_r;
    dirty_nxt      = dirty_r;
    q_head_nxt     = q_head_r;
    q_cnt_nxt      = q_cnt_r;
    run_valid_nxt  = run_valid_r;
    run_idx_nxt    = run_idx_r;
    phase_nxt      = phase_r;
    scan_i_nxt     = scan_i_r;
    rd_vld_nxt     = 1'b0;
    rd_idx_nxt     = rd_idx_r;
    qrd_vld_nxt    = 1'b0;
    qrd_k_nxt      = qrd_k_r;
    shift_k_nxt    = shift_k_r;
    sh_wr_vld_nxt  = 1'b0;
    sh_waddr_nxt   = sh_waddr_r;
    best_found_nxt = best_found_r;
    best_idx_nxt   = best_idx_r;
    best_arr_nxt   = best_arr_r;
    best_rem_nxt   = best_rem_r;
    best_prio_nxt  = best_prio_r;
    best_k_nxt     = best_k_r;
    out_valid_nxt  = 1'b0;
    out_id_nxt     = out_id_r;
    out_len_nxt    = out_len_r;
    out_status_nxt = out_status_r;
    tbl_we         = 1'b0;
    tbl_waddr      = count_r[IW-1:0];
    tbl_wdata      = '{id: in_task_id, prio: in_task_priority,
                       arr: in_arrival_time, burst: in_burst_time};
    tbl_re         = 1'b0;
    tbl_raddr      = scan_i_r[IW-1:0];
    rem_we         = 1'b0;
    rem_waddr      = rd_idx_r;
    rem_wdata      = '0;
    q_we           = 1'b0;
    q_waddr        = cts_pkg::qwrap(q_head_r, q_cnt_r);
    q_wdata        = '{idx: rd_idx_r, prio: tbl_rdata.prio};
    q_re           = 1'b0;
    q_raddr        = cts_pkg::qwrap(q_head_r, scan_i_r);
    len            = '0;
    t_base         = time_r;
    better         = 1'b0;

    unique case (state_r)
      cts_pkg::S_IDLE: begin
        if (start) begin
          unique case (cts_pkg::cmd_t'(in_cmd))
            cts_pkg::CMD_LOAD: begin
              if (count_r < CW'(MT)) begin
                tbl_we                     = 1'b1;
                adm_nxt[count_r[IW-1:0]]   = 1'b0;
                dirty_nxt[count_r[IW-1:0]] = 1'b0;
                count_nxt                  = count_r + CW'(1);
              end
            end
            cts_pkg::CMD_CLEAR, cts_pkg::CMD_RESTART: begin
              if (in_cmd == cts_pkg::CMD_CLEAR) begin
                count_nxt = '0;
              end
              adm_nxt       = '0;
              dirty_nxt     = '0;
              time_nxt      = '0;
              q_head_nxt    = '0;
              q_cnt_nxt     = '0;
              run_valid_nxt = 1'b0;
            end
            cts_pkg::CMD_SLICE: begin
              if (mode_r <= cts_pkg::MODE_PRR) begin
                scan_i_nxt     = '0;
                best_found_nxt = 1'b0;
                phase_nxt      = 1'b0;
                state_nxt      = cts_pkg::S_SCAN;
                if (mode_r == cts_pkg::MODE_FCFS) begin
                  kind_nxt = cts_pkg::K_EARLY;
                end else if (mode_r <= cts_pkg::MODE_PRIO) begin
                  kind_nxt = cts_pkg::K_PICK;
                end else begin
                  kind_nxt = cts_pkg::K_ADMIT;
                end
              end
            end
            default: ;
          endcase
        end
      end

      cts_pkg::S_SCAN: begin
        if (scan_i_r < count_r) begin
          tbl_re     = 1'b1;
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = scan_i_r[IW-1:0];
          scan_i_nxt = scan_i_r + CW'(1);
        end
        if (rd_vld_r) begin
          unique case (kind_r)
            cts_pkg::K_ADMIT: begin
              if (pend && arrived) begin
                adm_nxt[rd_idx_r] = 1'b1;
                if (q_cnt_r < CW'(MT)) begin
                  q_we      = 1'b1;
                  q_cnt_nxt = q_cnt_r + CW'(1);
                end
              end
            end
            cts_pkg::K_EARLY: begin
              better = pend && (!best_found_r || tbl_rdata.arr < best_arr_r);
            end
            cts_pkg::K_PICK: begin
              better = pend && arrived && (!best_found_r ||
                       ((mode_r == cts_pkg::MODE_SJF) ? (rem_eff < best_rem_r)
                                                      : (tbl_rdata.prio > best_prio_r)));
            end
            default: ;
          endcase
          if (better) begin
            best_found_nxt = 1'b1;
            best_idx_nxt   = rd_idx_r;
            best_arr_nxt   = tbl_rdata.arr;
            best_rem_nxt   = rem_eff;
            best_prio_nxt  = tbl_rdata.prio;
          end
        end else if (scan_i_r >= count_r) begin
          scan_i_nxt     = '0;
          best_found_nxt = 1'b0;
          unique case (kind_r)
            cts_pkg::K_ADMIT: begin
              if (phase_r) begin
                state_nxt = cts_pkg::S_QSCAN;
              end else if (run_valid_r) begin
                state_nxt = cts_pkg::S_RUN_RD;
              end else begin
                state_nxt = cts_pkg::S_QCHK;
              end
            end
            cts_pkg::K_EARLY: begin
              if (!best_found_r) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = 1'b1;
                out_id_nxt     = '0;
                out_len_nxt    = '0;
                state_nxt      = cts_pkg::S_IDLE;
              end else if (mode_r == cts_pkg::MODE_FCFS) begin
                state_nxt = cts_pkg::S_TASK_RD;
              end else begin
                time_nxt = cts_pkg::TIME_W'(best_arr_r);
                if (mode_r <= cts_pkg::MODE_PRIO) begin
                  kind_nxt = cts_pkg::K_PICK;
                end else begin
                  kind_nxt  = cts_pkg::K_ADMIT;
                  phase_nxt = 1'b1;
                end
              end
            end
            cts_pkg::K_PICK: begin
              if (best_found_r) begin
                state_nxt = cts_pkg::S_TASK_RD;
              end else if (!phase_r) begin
                kind_nxt  = cts_pkg::K_EARLY;
                phase_nxt = 1'b1;
              end else begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = 1'b1;
                out_id_nxt     = '0;
                out_len_nxt    = '0;
                state_nxt      = cts_pkg::S_IDLE;
              end
            end
            default: state_nxt = cts_pkg::S_IDLE;
          endcase
        end
      end

      cts_pkg::S_RUN_RD: begin
        tbl_re     = 1'b1;
        tbl_raddr  = run_idx_r;
        rd_idx_nxt = run_idx_r;
        state_nxt  = cts_pkg::S_RUN_CHK;
      end

      cts_pkg::S_RUN_CHK: begin
        // preempted task goes behind the new arrivals
        if (rem_eff != '0 && q_cnt_r < CW'(MT)) begin
          q_we      = 1'b1;
          q_cnt_nxt = q_cnt_r + CW'(1);
        end
        run_valid_nxt = 1'b0;
        state_nxt     = cts_pkg::S_QCHK;
      end

      cts_pkg::S_QCHK: begin
        scan_i_nxt     = '0;
        best_found_nxt = 1'b0;
        if (q_cnt_r == '0) begin
          kind_nxt  = cts_pkg::K_EARLY;
          state_nxt = cts_pkg::S_SCAN;
        end else begin
          state_nxt = cts_pkg::S_QSCAN;
        end
      end

      cts_pkg::S_QSCAN: begin
        if (scan_i_r < q_cnt_r) begin
          q_re        = 1'b1;
          qrd_vld_nxt = 1'b1;
          qrd_k_nxt   = scan_i_r;
          scan_i_nxt  = scan_i_r + CW'(1);
        end
        if (qrd_vld_r) begin
          if (!best_found_r ||
              (mode_r == cts_pkg::MODE_PRR && q_rdata.prio > best_prio_r)) begin
            best_found_nxt = 1'b1;
            best_k_nxt     = qrd_k_r;
            best_idx_nxt   = q_rdata.idx;
            best_prio_nxt  = q_rdata.prio;
          end
        end else if (scan_i_r >= q_cnt_r) begin
          shift_k_nxt = best_k_r;
          state_nxt   = cts_pkg::S_SHIFT;
        end
      end

      cts_pkg::S_SHIFT: begin
        // close the gap: entries ahead of the pick move back one place
        if (sh_wr_vld_r) begin
          q_we    = 1'b1;
          q_waddr = sh_waddr_r;
          q_wdata = q_rdata;
        end
        if (shift_k_r != '0) begin
          q_re          = 1'b1;
          q_raddr       = cts_pkg::qwrap(q_head_r, shift_k_r - CW'(1));
          sh_wr_vld_nxt = 1'b1;
          sh_waddr_nxt  = cts_pkg::qwrap(q_head_r, shift_k_r);
          shift_k_nxt   = shift_k_r - CW'(1);
        end else if (!sh_wr_vld_r) begin
          q_head_nxt = cts_pkg::qwrap(q_head_r, CW'(1));
          q_cnt_nxt  = q_cnt_r - CW'(1);
          state_nxt  = cts_pkg::S_TASK_RD;
        end
      end

      cts_pkg::S_TASK_RD: begin
        tbl_re     = 1'b1;
        tbl_raddr  = best_idx_r;
        rd_idx_nxt = best_idx_r;
        state_nxt  = cts_pkg::S_TASK_UPD;
      end

      cts_pkg::S_TASK_UPD: begin
        rem_we       = 1'b1;
        dirty_nxt[rd_idx_r] = 1'b1;
        if (mode_r >= cts_pkg::MODE_RR) begin
          len           = (rem_eff < q_eff) ? rem_eff : q_eff;
          rem_wdata     = rem_eff - len;
          run_valid_nxt = 1'b1;
          run_idx_nxt   = rd_idx_r;
        end else begin
          len               = rem_eff;
          adm_nxt[rd_idx_r] = 1'b1;
          if (cts_pkg::TIME_W'(tbl_rdata.arr) > time_r) begin
            t_base = cts_pkg::TIME_W'(tbl_rdata.arr);
          end
        end
        time_nxt       = t_base + cts_pkg::TIME_W'(len);
        out_valid_nxt  = 1'b1;
        out_status_nxt = 1'b0;
        out_id_nxt     = tbl_rdata.id;
        out_len_nxt    = len;
        state_nxt      = cts_pkg::S_IDLE;
      end

      default: state_nxt = cts_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cts_pkg::S_IDLE;
      count_r     <= '0;
      time_r      <= '0;
      adm_r       <= '0;
      dirty_r     <= '0;
      q_head_r    <= '0;
      q_cnt_r     <= '0;
      run_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
      qrd_vld_r   <= 1'b0;
      sh_wr_vld_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      time_r      <= time_nxt;
      adm_r       <= adm_nxt;
      dirty_r     <= dirty_nxt;
      q_head_r    <= q_head_nxt;
      q_cnt_r     <= q_cnt_nxt;
      run_valid_r <= run_valid_nxt;
      rd_vld_r    <= rd_vld_nxt;
      qrd_vld_r   <= qrd_vld_nxt;
      sh_wr_vld_r <= sh_wr_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    run_idx_r    <= run_idx_nxt;
    phase_r      <= phase_nxt;
    scan_i_r     <= scan_i_nxt;
    rd_idx_r     <= rd_idx_nxt;
    qrd_k_r      <= qrd_k_nxt;
    shift_k_r    <= shift_k_nxt;
    sh_waddr_r   <= sh_waddr_nxt;
    best_found_r <= best_found_nxt;
    best_idx_r   <= best_idx_nxt;
    best_arr_r   <= best_arr_nxt;
    best_rem_r   <= best_rem_nxt;
    best_prio_r  <= best_prio_nxt;
    best_k_r     <= best_k_nxt;
    out_id_r     <= out_id_nxt;
    out_len_r    <= out_len_nxt;
    out_status_r <= out_status_nxt;
  end

  assign busy              = (state_r != cts_pkg::S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_slice_task_id = out_id_r;
  assign out_slice_length  = out_len_r;
  assign out_status        = out_status_r;

  `CTS_ASSERT_IMPL(a_qcnt_le_tasks, 1'b1, q_cnt_r <= count_r, "queue holds more than the table")
  `CTS_ASSERT_IMPL(a_run_in_table, run_valid_r, run_idx_r < count_r[IW-1:0] || count_r == CW'(MT), "running task outside table")
  `CTS_ASSERT_IMPL(a_result_idle, out_valid_r, state_r == cts_pkg::S_IDLE, "result while still busy")
  `CTS_ASSERT_NEXT(a_slice_busy, start && !busy && in_cmd == cts_pkg::CMD_SLICE && mode_r <= cts_pkg::MODE_PRR, busy, "slice transaction did not start")

endmodule

`default_nettype wire
